FILE: rtl/rra_pkg.sv
// ----------------------------------------------------------------------------
// rra_pkg: shared types and constants of the rounded rectangle fill unit
// Configuration layout, register indexes, pixel side data and the widths of
// the square root cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rra_pkg;

  localparam int FRAME_WIDTH_DEF  = 1024;
  localparam int FRAME_HEIGHT_DEF = 1024;

  localparam int PIX_W       = 10;  // pixel coordinate width
  localparam int RGB_W       = 24;
  localparam int CH_W        = 8;   // one color channel
  localparam int NUM_CH      = 3;
  localparam int COORD_W     = 14;  // signed room for left + width - radius
  localparam int FRAME_CMP_W = 13;  // holds frame sizes up to 4096
  localparam int DIST_W      = 8;   // dx and dy never exceed the radius inside the rectangle

  // Square root chain: radicand is (dx^2 + dy^2) << 16, one result bit per cell
  localparam int SQ_W       = 2 * DIST_W + 1;
  localparam int FRAC_W     = 16;
  localparam int RAD_W      = 34;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int ROOT_W     = ROOT_STEPS;
  localparam int REM_W      = ROOT_W + 2;

  // floor(m / 255) == (m * RECIP_255) >> RECIP_SHIFT for m < 65536
  localparam int RECIP_255   = 32897;
  localparam int RECIP_SHIFT = 23;
  localparam int MAG_W       = 16;
  localparam int PROD_W      = 2 * MAG_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECT_LEFT     = 3'd0,
    CFG_RECT_TOP      = 3'd1,
    CFG_RECT_WIDTH    = 3'd2,
    CFG_RECT_HEIGHT   = 3'd3,
    CFG_CORNER_RADIUS = 3'd4,
    CFG_FILL_RGB      = 3'd5,
    CFG_FILL_ALPHA    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [10:0] rect_left;
    logic signed [10:0] rect_top;
    logic [11:0]        rect_width;
    logic [11:0]        rect_height;
    logic [7:0]         corner_radius;
    logic [RGB_W-1:0]   fill_rgb;
    logic [7:0]         fill_alpha;
  } cfg_t;

  // Side data that travels with a pixel down the pipeline
  typedef struct packed {
    logic             in_rect;  // within frame and rectangle
    logic             band;     // in an edge or corner band
    logic [RGB_W-1:0] bg;
  } pix_meta_t;

endpackage

`default_nettype wire

FILE: rtl/rra_geom.sv
// ----------------------------------------------------------------------------
// rra_geom: rectangle test and squared corner distance
// Stage one finds whether the pixel lies inside and its offsets dx, dy from
// the corner centre; stage two forms dx^2 + dy^2.
// ----------------------------------------------------------------------------
`default_nettype none

module rra_geom #(
  parameter int FRAME_WIDTH  = rra_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = rra_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [rra_pkg::PIX_W-1:0] pix_x,
  input  logic [rra_pkg::PIX_W-1:0] pix_y,
  input  logic [rra_pkg::RGB_W-1:0] bg_rgb,
  input  rra_pkg::cfg_t             cfg,
  output logic                      out_valid,
  output rra_pkg::pix_meta_t        out_meta,
  output logic [rra_pkg::SQ_W-1:0]  out_sq
);

  import rra_pkg::*;

  logic signed [COORD_W-1:0] xs, ys, left_s, top_s, w_s, h_s, r_s;
  logic signed [COORD_W-1:0] x_end, y_end, x_lo, y_lo, x_hi, y_hi;
  logic signed [COORD_W-1:0] dx_full, dy_full;
  logic                      in_frame, in_rect;
  logic [DIST_W-1:0]         dx, dy;

  logic              s1_valid;
  pix_meta_t         s1_meta;
  logic [DIST_W-1:0] s1_dx, s1_dy;
  logic [15:0]       dx2, dy2;

  assign xs     = $signed(COORD_W'(pix_x));
  assign ys     = $signed(COORD_W'(pix_y));
  assign left_s = $signed({{(COORD_W-11){cfg.rect_left[10]}}, cfg.rect_left});
  assign top_s  = $signed({{(COORD_W-11){cfg.rect_top[10]}}, cfg.rect_top});
  assign w_s    = $signed(COORD_W'(cfg.rect_width));
  assign h_s    = $signed(COORD_W'(cfg.rect_height));
  assign r_s    = $signed(COORD_W'(cfg.corner_radius));

  assign x_end = left_s + w_s;
  assign y_end = top_s + h_s;
  assign x_lo  = left_s + r_s;
  assign y_lo  = top_s + r_s;
  assign x_hi  = x_end - r_s;
  assign y_hi  = y_end - r_s;

  assign in_frame = (FRAME_CMP_W'(pix_x) < FRAME_CMP_W'(FRAME_WIDTH)) &&
                    (FRAME_CMP_W'(pix_y) < FRAME_CMP_W'(FRAME_HEIGHT));
  assign in_rect  = in_frame && (xs >= left_s) && (xs < x_end) &&
                    (ys >= top_s) && (ys < y_end);

  // Left and top bands take precedence when the radius exceeds half the size
  always_comb begin
    priority if (xs < x_lo) begin
      dx_full = x_lo - xs;
    end else if (xs >= x_hi) begin
      dx_full = xs - x_hi + COORD_W'(1);
    end else begin
      dx_full = '0;
    end
    priority if (ys < y_lo) begin
      dy_full = y_lo - ys;
    end else if (ys >= y_hi) begin
      dy_full = ys - y_hi + COORD_W'(1);
    end else begin
      dy_full = '0;
    end
  end

  assign dx = dx_full[DIST_W-1:0];
  assign dy = dy_full[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_meta.in_rect <= in_rect;
    s1_meta.band    <= (dx != '0) || (dy != '0);
    s1_meta.bg      <= bg_rgb;
    s1_dx           <= dx;
    s1_dy           <= dy;
  end

  assign dx2 = {8'b0, s1_dx} * {8'b0, s1_dx};
  assign dy2 = {8'b0, s1_dy} * {8'b0, s1_dy};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_meta <= s1_meta;
    out_sq   <= {1'b0, dx2} + {1'b0, dy2};
  end

endmodule

`default_nettype wire

FILE: rtl/rra_root_cell.sv
// ----------------------------------------------------------------------------
// rra_root_cell: one digit of a restoring square root
// Takes the next two radicand bits into the partial remainder, decides one
// root bit and hands remainder, root and pixel data to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rra_root_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  rra_pkg::pix_meta_t         in_meta,
  input  logic [rra_pkg::RAD_W-1:0]  in_rad,
  input  logic [rra_pkg::REM_W-1:0]  in_rem,
  input  logic [rra_pkg::ROOT_W-1:0] in_root,
  output logic                       out_valid,
  output rra_pkg::pix_meta_t         out_meta,
  output logic [rra_pkg::RAD_W-1:0]  out_rad,
  output logic [rra_pkg::REM_W-1:0]  out_rem,
  output logic [rra_pkg::ROOT_W-1:0] out_root
);

  import rra_pkg::*;

  logic [REM_W+1:0]  trem, trial, diff;
  logic              take;
  logic [REM_W-1:0]  rem_next;
  logic [ROOT_W-1:0] root_next;

  assign trem  = {in_rem, in_rad[RAD_W-1 -: 2]};
  assign trial = {{(REM_W-ROOT_W){1'b0}}, in_root, 2'b01};
  assign diff  = trem - trial;
  assign take  = (trem >= trial);

  always_comb begin
    if (take) begin
      rem_next  = diff[REM_W-1:0];
      root_next = {in_root[ROOT_W-2:0], 1'b1};
    end else begin
      rem_next  = trem[REM_W-1:0];
      root_next = {in_root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_meta <= in_meta;
    out_rad  <= {in_rad[RAD_W-3:0], 2'b00};
    out_rem  <= rem_next;
    out_root <= root_next;
  end

endmodule

`default_nettype wire

FILE: rtl/rra_blend.sv
// ----------------------------------------------------------------------------
// rra_blend: coverage alpha and per-channel blend
// Turns the corner distance into an alpha, then forms
// bg + trunc((fg - bg) * a / 255) for each channel over two more stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rra_blend (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  rra_pkg::pix_meta_t         in_meta,
  input  logic [rra_pkg::ROOT_W-1:0] in_dist,
  input  rra_pkg::cfg_t              cfg,
  output logic                       out_valid,
  output logic [rra_pkg::RGB_W-1:0]  out_rgb,
  output logic                       out_written
);

  import rra_pkg::*;

  // Alpha stage
  logic [ROOT_W-1:0] rq, rq_minus;
  logic              over, near;
  logic [15:0]       scaled;
  logic [7:0]        a_band, a_sel;
  logic              wr;

  logic             t1_valid, t1_written;
  logic [7:0]       t1_alpha;
  logic [RGB_W-1:0] t1_bg;

  logic                    t2_valid, t2_written;
  logic [RGB_W-1:0]        t2_bg;
  logic signed [17:0]      t2_prod [NUM_CH];
  logic [CH_W-1:0]         blended [NUM_CH];

  assign rq       = {1'b0, cfg.corner_radius, 8'b0};
  assign rq_minus = rq - in_dist;
  assign over     = (in_dist > rq);
  assign near     = (cfg.corner_radius != '0) && (in_dist > (rq - ROOT_W'(256)));
  assign scaled   = {8'b0, cfg.fill_alpha} * {8'b0, rq_minus[7:0]};
  assign a_band   = near ? scaled[15:8] : cfg.fill_alpha;
  assign a_sel    = in_meta.band ? a_band : cfg.fill_alpha;
  // Drop band pixels past the radius or with no coverage left
  assign wr       = in_meta.in_rect && !(in_meta.band && (over || (a_band == '0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
    end else begin
      t1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    t1_written <= wr;
    t1_alpha   <= a_sel;
    t1_bg      <= in_meta.bg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_valid <= 1'b0;
    end else begin
      t2_valid <= t1_valid;
    end
  end

  always_ff @(posedge clk) begin
    t2_written <= t1_written;
    t2_bg      <= t1_bg;
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic [CH_W-1:0]    fg_c, bg_c, bg2_c, q;
    logic signed [8:0]  diff_c;
    logic [MAG_W-1:0]   mag;
    logic [PROD_W-1:0]  recip;

    assign fg_c   = cfg.fill_rgb[c*CH_W +: CH_W];
    assign bg_c   = t1_bg[c*CH_W +: CH_W];
    assign diff_c = $signed({1'b0, fg_c}) - $signed({1'b0, bg_c});

    always_ff @(posedge clk) begin
      t2_prod[c] <= diff_c * $signed({1'b0, t1_alpha});
    end

    // Divide the magnitude by 255, then restore the sign (truncates to zero)
    assign mag   = t2_prod[c][17] ? MAG_W'(-t2_prod[c]) : MAG_W'(t2_prod[c]);
    assign recip = {{(PROD_W-MAG_W){1'b0}}, mag} * PROD_W'(RECIP_255);
    assign q     = recip[RECIP_SHIFT +: CH_W];
    assign bg2_c = t2_bg[c*CH_W +: CH_W];
    assign blended[c] = t2_prod[c][17] ? (bg2_c - q) : (bg2_c + q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= t2_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_written <= t2_written;
    out_rgb     <= t2_written ? {blended[2], blended[1], blended[0]} : t2_bg;
  end

endmodule

`default_nettype wire

FILE: rtl/rounded_rect_alpha_fill_unit.sv
// ----------------------------------------------------------------------------
// rounded_rect_alpha_fill_unit: rounded rectangle alpha compositor
// Takes one pixel per clock and returns it with the configured rounded
// rectangle blended over it.
// ----------------------------------------------------------------------------
// The unit accepts a pixel on every clock at which start is high; busy is
// never raised. Each pixel's result appears on out_rgb and written with done
// high for one cycle, in input order. The pipeline is the corner distance
// square root, a chain of 17 cells that each settle one root bit per clock,
// plus input, geometry, squaring, alpha and two blend stages. Results cannot
// be held off, so the receiver must take each one in its cycle. Registers are
// written through cfg_valid/cfg_ready (always ready); change them only while
// no pixel is in flight.
`default_nettype none

module rounded_rect_alpha_fill_unit #(
  parameter int FRAME_WIDTH  = rra_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = rra_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [rra_pkg::PIX_W-1:0]      pix_x,
  input  logic [rra_pkg::PIX_W-1:0]      pix_y,
  input  logic [rra_pkg::RGB_W-1:0]      bg_rgb,
  output logic                           done,
  output logic [rra_pkg::RGB_W-1:0]      out_rgb,
  output logic                           written,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rra_pkg::CFG_DATA_W-1:0] cfg_data
);

  import rra_pkg::*;

  cfg_t cfg;

  logic             in_valid;
  logic [PIX_W-1:0] in_x, in_y;
  logic [RGB_W-1:0] in_bg;

  logic             g_valid;
  pix_meta_t        g_meta;
  logic [SQ_W-1:0]  g_sq;

  logic              chain_valid [ROOT_STEPS+1];
  pix_meta_t         chain_meta  [ROOT_STEPS+1];
  logic [RAD_W-1:0]  chain_rad   [ROOT_STEPS+1];
  logic [REM_W-1:0]  chain_rem   [ROOT_STEPS+1];
  logic [ROOT_W-1:0] chain_root  [ROOT_STEPS+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rect_left     <= '0;
      cfg.rect_top      <= '0;
      cfg.rect_width    <= '0;
      cfg.rect_height   <= '0;
      cfg.corner_radius <= '0;
      cfg.fill_rgb      <= '0;
      cfg.fill_alpha    <= 8'hFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RECT_LEFT:     cfg.rect_left     <= $signed(cfg_data[10:0]);
        CFG_RECT_TOP:      cfg.rect_top      <= $signed(cfg_data[10:0]);
        CFG_RECT_WIDTH:    cfg.rect_width    <= cfg_data[11:0];
        CFG_RECT_HEIGHT:   cfg.rect_height   <= cfg_data[11:0];
        CFG_CORNER_RADIUS: cfg.corner_radius <= cfg_data[7:0];
        CFG_FILL_RGB:      cfg.fill_rgb      <= cfg_data[RGB_W-1:0];
        CFG_FILL_ALPHA:    cfg.fill_alpha    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_x  <= pix_x;
    in_y  <= pix_y;
    in_bg <= bg_rgb;
  end

  rra_geom #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .pix_x     (in_x),
    .pix_y     (in_y),
    .bg_rgb    (in_bg),
    .cfg       (cfg),
    .out_valid (g_valid),
    .out_meta  (g_meta),
    .out_sq    (g_sq)
  );

  // Radicand is the squared distance with 16 fraction bits
  assign chain_valid[0] = g_valid;
  assign chain_meta[0]  = g_meta;
  assign chain_rad[0]   = {{(RAD_W-SQ_W-FRAC_W){1'b0}}, g_sq, {FRAC_W{1'b0}}};
  assign chain_rem[0]   = '0;
  assign chain_root[0]  = '0;

  for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_cell
    rra_root_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_meta   (chain_meta[i]),
      .in_rad    (chain_rad[i]),
      .in_rem    (chain_rem[i]),
      .in_root   (chain_root[i]),
      .out_valid (chain_valid[i+1]),
      .out_meta  (chain_meta[i+1]),
      .out_rad   (chain_rad[i+1]),
      .out_rem   (chain_rem[i+1]),
      .out_root  (chain_root[i+1])
    );
  end

  rra_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (chain_valid[ROOT_STEPS]),
    .in_meta     (chain_meta[ROOT_STEPS]),
    .in_dist     (chain_root[ROOT_STEPS]),
    .cfg         (cfg),
    .out_valid   (done),
    .out_rgb     (out_rgb),
    .out_written (written)
  );

endmodule

`default_nettype wire

FILE: verif/rra_fill_monitor.sv
// ----------------------------------------------------------------------------
// rra_fill_monitor: result checker for the rounded rectangle fill unit
// Tracks register writes and accepted pixels, works out the composited color
// of each pixel and checks every result word against the oldest one waiting.
// ----------------------------------------------------------------------------
module rra_fill_monitor
  import rra_pkg::*;
#(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [PIX_W-1:0]      pix_x,
  input  logic [PIX_W-1:0]      pix_y,
  input  logic [RGB_W-1:0]      bg_rgb,
  input  logic                  done,
  input  logic [RGB_W-1:0]      out_rgb,
  input  logic                  written,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNEL_MAX  = 255;
  localparam int REPORT_LIMIT = 10;
  localparam int ROOT_TOP_BIT = 20;

  typedef struct packed {
    logic [RGB_W-1:0] rgb;
    logic             written;
  } pixel_result_t;

  cfg_t          regs;
  pixel_result_t expected_pixels[$];
  int            errors = 0;
  int            results_seen = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Largest root whose square does not exceed v, one bit at a time.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = ROOT_TOP_BIT; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic pixel_result_t composite_pixel(cfg_t c, logic [PIX_W-1:0] px,
                                                    logic [PIX_W-1:0] py,
                                                    logic [RGB_W-1:0] bg);
    int x, y, left, top, w, h, r, dx, dy, alpha, ch_bg, ch_fg, mixed;
    longint unsigned dist_sq, dq, rq;
    pixel_result_t res;
    x = px;
    y = py;
    left = $signed(c.rect_left);
    top = $signed(c.rect_top);
    w = c.rect_width;
    h = c.rect_height;
    r = c.corner_radius;
    alpha = c.fill_alpha;
    res.rgb = bg;
    res.written = 1'b0;
    if (!(x < FRAME_WIDTH && y < FRAME_HEIGHT && x >= left && x < left + w &&
          y >= top && y < top + h))
      return res;

    // Left and top bands take precedence when the radius overlaps both sides.
    dx = 0;
    dy = 0;
    if (x < left + r) dx = left + r - x;
    else if (x >= left + w - r) dx = x - (left + w - r - 1);
    if (y < top + r) dy = top + r - y;
    else if (y >= top + h - r) dy = y - (top + h - r - 1);

    if (dx != 0 || dy != 0) begin
      dist_sq = longint'(dx * dx + dy * dy);
      dq = floor_root(dist_sq << 16);
      rq = longint'(r) << 8;
      if (dq > rq) return res;
      // Fade alpha across the last pixel before the radius.
      if (r >= 1 && dq > rq - 256) alpha = int'((longint'(c.fill_alpha) * (rq - dq)) >> 8);
      if (alpha <= 0) return res;
    end

    for (int ch = 0; ch < NUM_CH; ch++) begin
      ch_bg = bg[CH_W*ch +: CH_W];
      ch_fg = c.fill_rgb[CH_W*ch +: CH_W];
      mixed = ch_bg + ((ch_fg - ch_bg) * alpha) / CHANNEL_MAX;
      res.rgb[CH_W*ch +: CH_W] = mixed[CH_W-1:0];
    end
    res.written = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    if (rst) begin
      regs = '0;
      regs.fill_alpha = 8'(CHANNEL_MAX);
      expected_pixels.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      if (done) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: result word %0d with no pixel pending: out_rgb %06h written %0b",
                     $time, results_seen, out_rgb, written);
        end else begin
          want = expected_pixels.pop_front();
          if (out_rgb !== want.rgb || written !== want.written) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("%0t: result word %0d: out_rgb %06h written %0b, expected %06h %0b",
                       $time, results_seen, out_rgb, written, want.rgb, want.written);
          end
        end
      end
      if (start && !busy)
        expected_pixels.push_back(composite_pixel(regs, pix_x, pix_y, bg_rgb));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RECT_LEFT:     regs.rect_left = cfg_data[10:0];
          CFG_RECT_TOP:      regs.rect_top = cfg_data[10:0];
          CFG_RECT_WIDTH:    regs.rect_width = cfg_data[11:0];
          CFG_RECT_HEIGHT:   regs.rect_height = cfg_data[11:0];
          CFG_CORNER_RADIUS: regs.corner_radius = cfg_data[7:0];
          CFG_FILL_RGB:      regs.fill_rgb = cfg_data[RGB_W-1:0];
          CFG_FILL_ALPHA:    regs.fill_alpha = cfg_data[7:0];
          default: ;  // drop writes to unmapped indexes
        endcase
      end
    end
    mismatches <= errors;
    outstanding <= expected_pixels.size();
  end

endmodule

FILE: verif/rounded_rect_alpha_fill_unit_test.sv
// ----------------------------------------------------------------------------
// rounded_rect_alpha_fill_unit_test: top level bench of the fill unit
// Drives register settings and pixel words into the unit: directed corner,
// edge and extreme cases first, then random settings with pixels aimed at the
// rectangle's bands, under three sender idle profiles. A monitor checks every
// result word.
// ----------------------------------------------------------------------------
module rounded_rect_alpha_fill_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rra_pkg::*;

  localparam int CLK_PERIOD         = 10;
  localparam int RESET_CYCLES       = 4;
  localparam int DRAIN_CYCLES       = 32;
  localparam int QUIET_LIMIT        = 2000;
  localparam int PHASES             = 3;
  localparam int SETTINGS_PER_PHASE = 5;
  localparam int PIXELS_PER_SETTING = 84;
  localparam int SENDER_IDLE_LIGHT  = 31;
  localparam int SENDER_IDLE_HEAVY  = 67;
  localparam int FRAME_MAX          = 1023;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [PIX_W-1:0]      pix_x = '0;
  logic [PIX_W-1:0]      pix_y = '0;
  logic [RGB_W-1:0]      bg_rgb = '0;
  logic                  done;
  logic [RGB_W-1:0]      out_rgb;
  logic                  written;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    outstanding;
  int                    quiet_cycles = 0;
  int                    idle_pct = 0;
  cfg_t                  cur_cfg;

  rounded_rect_alpha_fill_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pix_x(pix_x), .pix_y(pix_y), .bg_rgb(bg_rgb),
    .done(done), .out_rgb(out_rgb), .written(written),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rra_fill_monitor fill_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pix_x(pix_x), .pix_y(pix_y), .bg_rgb(bg_rgb),
    .done(done), .out_rgb(out_rgb), .written(written),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Count cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("rounded_rect_alpha_fill_unit_test failed");
    $finish;
  end

  function automatic cfg_t make_setting(int left, int top, int w, int h, int r,
                                        logic [RGB_W-1:0] rgb, int alpha);
    cfg_t c;
    c.rect_left = 11'(left);
    c.rect_top = 11'(top);
    c.rect_width = 12'(w);
    c.rect_height = 12'(h);
    c.corner_radius = 8'(r);
    c.fill_rgb = rgb;
    c.fill_alpha = 8'(alpha);
    return c;
  endfunction

  function automatic int pick_origin();
    case ($urandom_range(7))
      0: return -1024;
      1: return FRAME_MAX;
      default: return int'($urandom_range(1000)) - 40;
    endcase
  endfunction

  function automatic int pick_span();
    case ($urandom_range(9))
      0: return 0;
      1: return 1;
      2: return 2048;
      3: return $urandom_range(4095);
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  function automatic cfg_t random_setting();
    int left, top, w, h, r, alpha;
    left = pick_origin();
    top = pick_origin();
    w = pick_span();
    h = pick_span();
    case ($urandom_range(7))
      0: r = 0;
      1: r = 1;
      2: r = 255;
      3: r = $urandom_range(255);
      default: r = $urandom_range(40);
    endcase
    case ($urandom_range(5))
      0: alpha = 0;
      1: alpha = 255;
      default: alpha = $urandom_range(255);
    endcase
    return make_setting(left, top, w, h, r, 24'($urandom), alpha);
  endfunction

  // Aim most coordinates at the current rectangle, many at its bands and edges.
  function automatic int near_coord(int lo, int size, int r);
    int v;
    case ($urandom_range(4))
      0: v = lo - 2 + int'($urandom_range(r + 3));
      1: v = lo + size - r - 2 + int'($urandom_range(r + 4));
      2: v = lo + int'($urandom_range(size));
      default: v = $urandom_range(FRAME_MAX);
    endcase
    if (v < 0 || v > FRAME_MAX) v = $urandom_range(FRAME_MAX);
    return v;
  endfunction

  function automatic logic [RGB_W-1:0] pick_bg();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_pixel(int x, int y, logic [RGB_W-1:0] bg);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pix_x <= 10'(x);
    pix_y <= 10'(y);
    bg_rgb <= bg;
    do @(posedge clk); while (busy);
  endtask

  // Hold the sender until every pixel in flight has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Unused upper data bits carry noise; the unit must ignore them.
  task automatic load_setting(cfg_t c);
    drain();
    put_reg(CFG_UNMAPPED, 24'($urandom));
    put_reg(CFG_RECT_LEFT, {13'($urandom), c.rect_left});
    put_reg(CFG_RECT_TOP, {13'($urandom), c.rect_top});
    put_reg(CFG_RECT_WIDTH, {12'($urandom), c.rect_width});
    put_reg(CFG_RECT_HEIGHT, {12'($urandom), c.rect_height});
    put_reg(CFG_CORNER_RADIUS, {16'($urandom), c.corner_radius});
    put_reg(CFG_FILL_RGB, c.fill_rgb);
    put_reg(CFG_FILL_ALPHA, {16'($urandom), c.fill_alpha});
    cfg_valid <= 1'b0;
    cur_cfg = c;
  endtask

  initial begin
    int lo_x, lo_y;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Corners, fade ring, edges and just-outside pixels of a small rectangle
    load_setting(make_setting(100, 50, 64, 48, 12, 24'hFF8000, 255));
    send_pixel(100, 50, 24'h000000);
    send_pixel(104, 54, 24'hFFFFFF);
    send_pixel(130, 70, 24'h123456);
    send_pixel(101, 70, 24'hFFFFFF);
    send_pixel(100, 70, 24'h000000);
    send_pixel(163, 97, 24'h00FF00);
    send_pixel(160, 94, 24'h0000FF);
    send_pixel(99, 70, 24'hABCDEF);
    send_pixel(164, 70, 24'hABCDEF);
    send_pixel(130, 49, 24'h654321);
    send_pixel(130, 98, 24'h654321);
    send_pixel(0, 0, 24'hFFFFFF);
    send_pixel(FRAME_MAX, FRAME_MAX, 24'h000000);

    // No radius and a transparent fill: inside pixels are written unchanged
    load_setting(make_setting(100, 50, 64, 48, 0, 24'hFFFFFF, 0));
    send_pixel(100, 50, 24'h345678);
    send_pixel(163, 97, 24'hABCDEF);

    // A 2048 by 2048 rectangle with the largest radius from the most negative origin
    load_setting(make_setting(-1024, -1024, 2048, 2048, 255, 24'h00FF80, 128));
    send_pixel(0, 0, 24'hFFFFFF);
    send_pixel(FRAME_MAX, FRAME_MAX, 24'h000000);
    send_pixel(FRAME_MAX, 0, 24'h808080);
    send_pixel(900, 900, 24'h102030);

    // One-pixel rectangle at the far corner with the largest radius
    load_setting(make_setting(FRAME_MAX, FRAME_MAX, 1, 1, 255, 24'h0000FF, 255));
    send_pixel(FRAME_MAX, FRAME_MAX, 24'h00FF00);

    // Radius beyond half the rectangle: left and top bands win
    load_setting(make_setting(0, 0, 4, 4, 3, 24'hFF0000, 200));
    send_pixel(0, 0, 24'h00FFFF);
    send_pixel(3, 3, 24'h00FFFF);
    send_pixel(1, 2, 24'h00FFFF);
    send_pixel(2, 1, 24'h00FFFF);

    // Zero width covers nothing
    load_setting(make_setting(0, 0, 0, 2048, 5, 24'hFFFFFF, 255));
    send_pixel(0, 0, 24'h000000);

    for (int phase = 0; phase < PHASES; phase++) begin
      idle_pct = (phase == 0) ? SENDER_IDLE_LIGHT : (phase == 1) ? SENDER_IDLE_HEAVY : 0;
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
        load_setting(random_setting());
        lo_x = $signed(cur_cfg.rect_left);
        lo_y = $signed(cur_cfg.rect_top);
        for (int i = 0; i < PIXELS_PER_SETTING; i++)
          send_pixel(near_coord(lo_x, cur_cfg.rect_width, cur_cfg.corner_radius),
                     near_coord(lo_y, cur_cfg.rect_height, cur_cfg.corner_radius),
                     pick_bg());
      end
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("rounded_rect_alpha_fill_unit_test passed");
    end else begin
      $display("rounded_rect_alpha_fill_unit_test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rra_pkg.sv
rtl/rra_geom.sv
rtl/rra_root_cell.sv
rtl/rra_blend.sv
rtl/rounded_rect_alpha_fill_unit.sv
verif/rra_fill_monitor.sv
verif/rounded_rect_alpha_fill_unit_test.sv
